/* rtl/assert_macros.svh */
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define TWCC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every clock edge, reset included
`define TWCC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/twcc_pkg.sv */
`default_nettype none
package twcc_pkg;

  localparam int WORD_W     = 32;
  localparam int INDEX_W    = 12;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [1:0] FMT_PLAIN  = 2'd0;
  localparam logic [1:0] FMT_CHAIN  = 2'd1;
  localparam logic [1:0] FMT_SECTOR = 2'd2;

  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_BAD_HEADER = 2'd1;
  localparam logic [1:0] STATUS_BAD_SUM    = 2'd2;

  localparam logic [CFG_ADDR_W-1:0] REG_FORMAT  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_BUILD   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_TRACK   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_LENGTH  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_SECTORS = 3'd4;

  localparam logic [WORD_W-1:0] CHAIN_START = 32'hdec0ded1;

  localparam logic [1:0]         RESET_FORMAT  = FMT_CHAIN;
  localparam logic [INDEX_W-1:0] RESET_LENGTH  = 12'd1410;
  localparam logic [7:0]         RESET_SECTORS = 8'd11;

  typedef struct packed {
    logic [1:0]         format_mode;
    logic               build_direction;
    logic [7:0]         track_number;
    logic [INDEX_W-1:0] words_per_block;
    logic [7:0]         sectors_per_track;
  } cfg_t;

  // classified word travelling from front to back
  typedef struct packed {
    logic [WORD_W-1:0] data_word;
    logic              first;
    logic              last;
  } qent_t;

endpackage
`default_nettype wire

/* rtl/twcc_if.sv */
`default_nettype none
interface twcc_word_if import twcc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] data_word;
  modport source (output valid, output data_word, input ready);
  modport sink (input valid, input data_word, output ready);
endinterface

interface twcc_result_if import twcc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] out_word;
  logic              last_word;
  logic [1:0]        status;
  logic [7:0]        sector_number;
  modport source (output valid, output out_word, output last_word, output status,
                  output sector_number, input ready);
  modport sink (input valid, input out_word, input last_word, input status,
                input sector_number, output ready);
endinterface

interface twcc_cfg_if import twcc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* rtl/twcc_front.sv */
`default_nettype none
module twcc_front import twcc_pkg::*; #(
  parameter int MAX_BLOCK_WORDS = 4095
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cfg_t              cfg,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [WORD_W-1:0] in_word,
  output logic                   push_valid,
  input  wire logic              push_ready,
  output qent_t                  push_entry
);

  // longest block the index counter is allowed to reach
  localparam int LenCapInt = (MAX_BLOCK_WORDS < 4095) ? MAX_BLOCK_WORDS : 4095;
  localparam logic [INDEX_W-1:0] LEN_CAP = INDEX_W'(LenCapInt);
  localparam logic [INDEX_W-1:0] LEN_MIN = INDEX_W'(2);

  logic [INDEX_W-1:0] word_index;
  logic [INDEX_W-1:0] block_len;
  logic [INDEX_W:0]   index_inc;
  logic               is_last;
  logic               accept;

  always_comb begin
    if (cfg.words_per_block < LEN_MIN) begin
      block_len = LEN_MIN;
    end else if (cfg.words_per_block > LEN_CAP) begin
      block_len = LEN_CAP;
    end else begin
      block_len = cfg.words_per_block;
    end
  end

  assign index_inc = {1'b0, word_index} + {{INDEX_W{1'b0}}, 1'b1};
  assign is_last   = index_inc >= {1'b0, block_len};
  assign accept    = in_valid && push_ready;

  assign in_ready              = push_ready;
  assign push_valid            = in_valid;
  assign push_entry.data_word  = in_word;
  assign push_entry.first      = (word_index == '0);
  assign push_entry.last       = is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_index <= '0;
    end else if (accept) begin
      word_index <= is_last ? '0 : index_inc[INDEX_W-1:0];
    end
  end

endmodule
`default_nettype wire

/* rtl/twcc_queue.sv */
`default_nettype none
`include "assert_macros.svh"
module twcc_queue import twcc_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push_valid,
  output logic       push_ready,
  input  wire qent_t push_entry,
  output logic       pop_valid,
  input  wire logic  pop_ready,
  output qent_t      pop_entry
);

  qent_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_entry  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  `TWCC_ASSERT(a_count_bound, clk, rst, count <= 2'd2, "queue count beyond depth")
  `TWCC_ASSERT(a_push_grows, clk, rst, push && !pop |=> count == $past(count) + 2'd1,
               "queue count did not grow on push")

endmodule
`default_nettype wire

/* rtl/twcc_back.sv */
`default_nettype none
`include "assert_macros.svh"
module twcc_back import twcc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cfg_t        cfg,
  input  wire logic        track_write,
  input  wire logic        q_valid,
  output logic             q_ready,
  input  wire qent_t       q_entry,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [WORD_W-1:0] out_word,
  output logic             last_word,
  output logic [1:0]       status,
  output logic [7:0]       sector_number
);

  logic [WORD_W-1:0] chain_seed, chain_seed_next;
  logic [WORD_W-1:0] running_sum, running_sum_next;
  logic              header_bad, header_bad_next;
  logic [7:0]        current_sector, current_sector_next;
  logic [7:0]        build_sector_count, build_sector_count_next;

  logic [WORD_W-1:0] plain;
  logic [WORD_W-1:0] result;
  logic [1:0]        status_calc;
  logic [7:0]        sector_calc;
  logic [7:0]        sector_inc;
  logic              sectored;
  logic              chained;
  logic              pop;

  assign sectored   = (cfg.format_mode == FMT_SECTOR);
  assign chained    = (cfg.format_mode == FMT_CHAIN);
  assign q_ready    = !out_valid || out_ready;
  assign pop        = q_valid && q_ready;
  assign sector_inc = build_sector_count + 8'd1;

  always_comb begin
    chain_seed_next         = chain_seed;
    running_sum_next        = running_sum;
    header_bad_next         = header_bad;
    current_sector_next     = current_sector;
    build_sector_count_next = build_sector_count;
    plain                   = q_entry.data_word;
    result                  = q_entry.data_word;
    status_calc             = STATUS_OK;
    sector_calc             = 8'd0;

    if (!cfg.build_direction) begin
      if (q_entry.first) begin
        if (sectored) begin
          current_sector_next = q_entry.data_word[7:0];
          header_bad_next = (q_entry.data_word[15:8] != cfg.track_number) ||
                            (q_entry.data_word[7:0] >= cfg.sectors_per_track);
        end else begin
          current_sector_next = 8'd0;
          header_bad_next = (q_entry.data_word != {24'd0, 1'b0, cfg.track_number[7:1]});
        end
      end else if (chained) begin
        chain_seed_next = chain_seed ^ q_entry.data_word;
        plain           = chain_seed_next;
      end
      result = plain;
      if (q_entry.last) begin
        if (header_bad_next) begin
          status_calc = STATUS_BAD_HEADER;
        end else if (plain != running_sum) begin
          status_calc = STATUS_BAD_SUM;
        end
      end else begin
        running_sum_next = running_sum + plain;
      end
      sector_calc = sectored ? current_sector_next : 8'd0;
    end else begin
      if (q_entry.first) begin
        plain = sectored ? {16'd0, cfg.track_number, build_sector_count}
                         : {24'd0, 1'b0, cfg.track_number[7:1]};
      end else if (q_entry.last) begin
        plain = running_sum;
      end
      if (!q_entry.last) begin
        running_sum_next = running_sum + plain;
      end
      // in chain mode, encrypted word is plain xor previous plain word (chain start after the header)
      if (!q_entry.first && chained) begin
        result          = plain ^ chain_seed;
        chain_seed_next = plain;
      end else begin
        result = plain;
      end
      sector_calc = sectored ? build_sector_count : 8'd0;
      if (q_entry.last) begin
        build_sector_count_next = (sector_inc >= cfg.sectors_per_track) ? 8'd0 : sector_inc;
      end
    end

    if (q_entry.last) begin
      chain_seed_next  = CHAIN_START;
      running_sum_next = '0;
      header_bad_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_seed         <= CHAIN_START;
      running_sum        <= '0;
      header_bad         <= 1'b0;
      current_sector     <= 8'd0;
      build_sector_count <= 8'd0;
      out_valid          <= 1'b0;
    end else begin
      if (pop) begin
        chain_seed         <= chain_seed_next;
        running_sum        <= running_sum_next;
        header_bad         <= header_bad_next;
        current_sector     <= current_sector_next;
        out_valid          <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      // new track restarts the sector count
      if (track_write) begin
        build_sector_count <= 8'd0;
      end else if (pop) begin
        build_sector_count <= build_sector_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_word      <= result;
      last_word     <= q_entry.last;
      status        <= status_calc;
      sector_number <= sector_calc;
    end
  end

  `TWCC_ASSERT(a_status_on_last, clk, rst, out_valid && status != STATUS_OK |-> last_word,
               "status raised on a word that is not the last")
  `TWCC_ASSERT(a_restart_after_last, clk, rst,
               pop && q_entry.last |=> running_sum == '0 && chain_seed == CHAIN_START,
               "block state not restarted after last word")
  `TWCC_ASSERT(a_load_from_queue, clk, rst, $rose(out_valid) |-> $past(pop),
               "output loaded without a queue pop")

endmodule
`default_nettype wire

/* rtl/track_word_crypt_checksum.sv */
// track word checker and builder
//
// words: input channel, one decoded 32-bit block word per accepted word.
// results: output channel, one result word per input word, in order, with
//   last_word on the final word of each block and status there (verify only).
// cfg: register write channel, always ready; write only while no word is in
//   flight. index 0 format, 1 direction, 2 track, 3 block length, 4 sectors.
//
// a front stage counts words and marks first/last, a two-entry queue feeds
// the back stage that runs the xor chain, the sum and the header check into
// an output register. one word per cycle sustained while the receiver is
// ready; an accepted word goes into the queue, then the output register.
// the rate is set by the back stage, one queue entry per cycle when not stalled.
// when the receiver stalls the output register holds, the queue fills and
// words is held off while it is full. reset empties the queue, drops the
// output word and restores all registers and block state to their defaults.
`default_nettype none
module track_word_crypt_checksum import twcc_pkg::*; #(
  parameter int MAX_BLOCK_WORDS = 4095
) (
  input wire logic        clk,
  input wire logic        rst,
  twcc_word_if.sink       words,
  twcc_result_if.source   results,
  twcc_cfg_if.sink        cfg
);

  cfg_t  regs;
  logic  cfg_write;
  logic  track_write;
  logic  push_valid, push_ready;
  qent_t push_entry;
  logic  q_valid, q_ready;
  qent_t q_entry;

  assign cfg.ready   = 1'b1;
  assign cfg_write   = cfg.valid && cfg.ready;
  assign track_write = cfg_write && (cfg.index == REG_TRACK);

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.format_mode       <= RESET_FORMAT;
      regs.build_direction   <= 1'b0;
      regs.track_number      <= 8'd0;
      regs.words_per_block   <= RESET_LENGTH;
      regs.sectors_per_track <= RESET_SECTORS;
    end else if (cfg_write) begin
      case (cfg.index)
        REG_FORMAT:  regs.format_mode       <= cfg.data[1:0];
        REG_BUILD:   regs.build_direction   <= cfg.data[0];
        REG_TRACK:   regs.track_number      <= cfg.data[7:0];
        REG_LENGTH:  regs.words_per_block   <= cfg.data[INDEX_W-1:0];
        REG_SECTORS: regs.sectors_per_track <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

  twcc_front #(.MAX_BLOCK_WORDS(MAX_BLOCK_WORDS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (regs),
    .in_valid   (words.valid),
    .in_ready   (words.ready),
    .in_word    (words.data_word),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  twcc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_entry  (q_entry)
  );

  twcc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (regs),
    .track_write   (track_write),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_entry       (q_entry),
    .out_valid     (results.valid),
    .out_ready     (results.ready),
    .out_word      (results.out_word),
    .last_word     (results.last_word),
    .status        (results.status),
    .sector_number (results.sector_number)
  );

endmodule
`default_nettype wire

/* dv/tb_top.sv */
module tb_top;
  import twcc_pkg::*;

  localparam int MAX_BLOCK_WORDS = 4095;
  localparam int IDLE_PCT        = 11;
  localparam int DRAIN_CYCLES    = 4;
  localparam int WATCHDOG_LIMIT  = 1000;
  localparam int RANDOM_ITEMS    = 1750;
  localparam int CALM_FROM       = 800;
  localparam int CALM_TO         = 1150;

  localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 3'd7;

  typedef struct packed {
    logic [WORD_W-1:0] out_word;
    logic              last_word;
    logic [1:0]        status;
    logic [7:0]        sector;
  } res_t;

  typedef enum logic {ROW_REG, ROW_WORD} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_ADDR_W-1:0] idx;
    logic [CFG_DATA_W-1:0] val;
    logic [WORD_W-1:0]     word;
    logic                  known;
    res_t                  want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic rx_ready = 1'b0;

  twcc_word_if   word_ch ();
  twcc_result_if res_ch ();
  twcc_cfg_if    cfg_ch ();

  assign res_ch.ready = rx_ready;

  track_word_crypt_checksum #(.MAX_BLOCK_WORDS(MAX_BLOCK_WORDS)) dut (
    .clk     (clk),
    .rst     (rst),
    .words   (word_ch),
    .results (res_ch),
    .cfg     (cfg_ch)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // register copies and block state of the predictor
  logic [1:0]         cur_format  = FMT_CHAIN;
  logic               cur_build   = 1'b0;
  logic [7:0]         cur_track   = 8'd0;
  logic [INDEX_W-1:0] cur_length  = 12'd1410;
  logic [7:0]         cur_sectors = 8'd11;

  logic [INDEX_W-1:0] blk_pos      = '0;
  logic [WORD_W-1:0]  chain_val    = CHAIN_START;
  logic [WORD_W-1:0]  sum_acc      = '0;
  logic               hdr_bad      = 1'b0;
  logic [7:0]         hdr_sector   = '0;
  logic [7:0]         build_sector = '0;

  res_t pending_results[$];
  row_t plan[$];
  int   fail_count = 0;
  int   items_sent = 0;
  int   quiet_cycles = 0;
  bit   calm = 1'b0;
  bit   cfg_open = 1'b0;

  function automatic int eff_length();
    if (cur_length < 2) return 2;
    if (cur_length > MAX_BLOCK_WORDS) return MAX_BLOCK_WORDS;
    return int'(cur_length);
  endfunction

  function automatic void apply_reg(input logic [CFG_ADDR_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_FORMAT:  cur_format = val[1:0];
      REG_BUILD:   cur_build = val[0];
      REG_TRACK: begin
        cur_track = val[7:0];
        build_sector = '0;
      end
      REG_LENGTH:  cur_length = val;
      REG_SECTORS: cur_sectors = val[7:0];
      default: ;
    endcase
  endfunction

  function automatic res_t crypt_word(input logic [WORD_W-1:0] w);
    res_t       r;
    logic [WORD_W-1:0] p;
    logic [7:0] nxt;
    bit         is_last;
    bit         is_first;
    bit         sect;
    bit         chain;
    is_last  = int'(blk_pos) + 1 >= eff_length();
    is_first = blk_pos == 0;
    sect     = cur_format == FMT_SECTOR;
    chain    = cur_format == FMT_CHAIN;
    r = '0;
    if (!cur_build) begin
      if (is_first) begin
        p = w;
        if (sect) begin
          hdr_sector = w[7:0];
          hdr_bad = (w[15:8] != cur_track) || (w[7:0] >= cur_sectors);
        end else begin
          hdr_sector = '0;
          hdr_bad = w != {24'd0, 1'b0, cur_track[7:1]};
        end
      end else if (chain) begin
        chain_val = chain_val ^ w;
        p = chain_val;
      end else begin
        p = w;
      end
      r.out_word = p;
      if (is_last) begin
        if (hdr_bad) r.status = STATUS_BAD_HEADER;
        else if (p != sum_acc) r.status = STATUS_BAD_SUM;
        else r.status = STATUS_OK;
      end else begin
        sum_acc = sum_acc + p;
      end
      r.sector = sect ? hdr_sector : 8'd0;
    end else begin
      if (is_first) p = sect ? {16'd0, cur_track, build_sector} : {24'd0, 1'b0, cur_track[7:1]};
      else if (is_last) p = sum_acc;
      else p = w;
      if (!is_last) sum_acc = sum_acc + p;
      if (!is_first && chain) begin
        r.out_word = p ^ chain_val;
        chain_val = p;
      end else begin
        r.out_word = p;
      end
      r.sector = sect ? build_sector : 8'd0;
      if (is_last) begin
        nxt = build_sector + 8'd1;
        build_sector = (nxt >= cur_sectors) ? 8'd0 : nxt;
      end
    end
    r.last_word = is_last;
    if (is_last) begin
      blk_pos = '0;
      chain_val = CHAIN_START;
      sum_acc = '0;
      hdr_bad = 1'b0;
    end else begin
      blk_pos = blk_pos + 1'b1;
    end
    return r;
  endfunction

  function automatic void add_reg(input logic [CFG_ADDR_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
    row_t row;
    row = '0;
    row.kind = ROW_REG;
    row.idx = idx;
    row.val = val;
    plan.push_back(row);
  endfunction

  function automatic void add_word(input logic [WORD_W-1:0] w);
    row_t row;
    row = '0;
    row.kind = ROW_WORD;
    row.word = w;
    plan.push_back(row);
  endfunction

  function automatic void add_known(input logic [WORD_W-1:0] w, input logic [WORD_W-1:0] o,
                                    input logic l, input logic [1:0] s, input logic [7:0] sec);
    row_t row;
    row = '0;
    row.kind = ROW_WORD;
    row.word = w;
    row.known = 1'b1;
    row.want = '{out_word: o, last_word: l, status: s, sector: sec};
    plan.push_back(row);
  endfunction

  task automatic settle();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    if (!cfg_open) begin
      word_ch.valid <= 1'b0;
      settle();
    end
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    apply_reg(idx, val);
    cfg_open = 1'b1;
  endtask

  task automatic send_word(input logic [WORD_W-1:0] w, input logic known, input res_t want);
    res_t got;
    if (cfg_open) begin
      cfg_ch.valid <= 1'b0;
      cfg_open = 1'b0;
    end
    if (!calm) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        word_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    word_ch.valid     <= 1'b1;
    word_ch.data_word <= w;
    do @(posedge clk); while (!word_ch.ready);
    got = crypt_word(w);
    pending_results.push_back(known ? want : got);
    items_sent++;
    calm = items_sent >= CALM_FROM && items_sent < CALM_TO;
  endtask

  always @(posedge clk) rx_ready <= calm || $urandom_range(99) >= IDLE_PCT;

  always @(posedge clk) begin
    res_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result word %h with nothing expected", $time, res_ch.out_word);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (res_ch.out_word !== want.out_word) begin
          $display("%0t: out_word expected %h got %h", $time, want.out_word, res_ch.out_word);
          fail_count++;
        end
        if (res_ch.last_word !== want.last_word) begin
          $display("%0t: last_word expected %b got %b", $time, want.last_word,
                   res_ch.last_word);
          fail_count++;
        end
        if (res_ch.status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, res_ch.status);
          fail_count++;
        end
        if (res_ch.sector_number !== want.sector) begin
          $display("%0t: sector_number expected %0d got %0d", $time, want.sector,
                   res_ch.sector_number);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (word_ch.valid && word_ch.ready) || (res_ch.valid && res_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    int n;
    int bad_pos;
    int k;
    logic [WORD_W-1:0] p;
    logic [WORD_W-1:0] w;
    logic [WORD_W-1:0] prev;
    logic [WORD_W-1:0] run_sum;
    logic [CFG_DATA_W-1:0] val;

    word_ch.valid     <= 1'b0;
    word_ch.data_word <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= '0;
    cfg_ch.data       <= '0;

    // chained verify, track 0: good block, bad header wins, bad sum
    add_reg(REG_LENGTH, 12'd2);
    add_known(32'h0000_0000, 32'h0000_0000, 1'b0, STATUS_OK, 8'd0);
    add_known(32'hdec0_ded1, 32'h0000_0000, 1'b1, STATUS_OK, 8'd0);
    add_known(32'h0000_0005, 32'h0000_0005, 1'b0, STATUS_OK, 8'd0);
    add_known(32'hdec0_ded1, 32'h0000_0000, 1'b1, STATUS_BAD_HEADER, 8'd0);
    add_known(32'h0000_0000, 32'h0000_0000, 1'b0, STATUS_OK, 8'd0);
    add_known(32'hdec0_ded0, 32'h0000_0001, 1'b1, STATUS_BAD_SUM, 8'd0);
    // plain verify, top track, sum wraps
    add_reg(REG_FORMAT, {10'd0, FMT_PLAIN});
    add_reg(REG_TRACK, 12'h0ff);
    add_reg(REG_LENGTH, 12'd3);
    add_known(32'h0000_007f, 32'h0000_007f, 1'b0, STATUS_OK, 8'd0);
    add_known(32'hffff_ffff, 32'hffff_ffff, 1'b0, STATUS_OK, 8'd0);
    add_known(32'h0000_007e, 32'h0000_007e, 1'b1, STATUS_OK, 8'd0);
    // sectored verify: upper header bits ignored, sector at the count is bad
    add_reg(REG_FORMAT, {10'd0, FMT_SECTOR});
    add_reg(REG_SECTORS, 12'd11);
    add_reg(REG_TRACK, 12'h05a);
    add_known(32'hffff_5a0a, 32'hffff_5a0a, 1'b0, STATUS_OK, 8'h0a);
    add_word(32'h1234_5678);
    add_known(32'h1233_b082, 32'h1233_b082, 1'b1, STATUS_OK, 8'h0a);
    add_known(32'h0000_5a0b, 32'h0000_5a0b, 1'b0, STATUS_OK, 8'h0b);
    add_word(32'h0000_0000);
    add_known(32'h0000_0000, 32'h0000_0000, 1'b1, STATUS_BAD_HEADER, 8'h0b);
    // build direction, length below the minimum, unused index and format code
    add_reg(REG_SPARE, 12'hfff);
    add_reg(REG_BUILD, 12'd1);
    add_reg(REG_FORMAT, {10'd0, FMT_CHAIN});
    add_reg(REG_TRACK, 12'd200);
    add_reg(REG_LENGTH, 12'd0);
    add_known(32'ha5a5_a5a5, 32'd100, 1'b0, STATUS_OK, 8'd0);
    add_word(32'h5a5a_5a5a);
    add_reg(REG_FORMAT, 12'hfff);
    add_reg(REG_LENGTH, 12'd1);
    add_known(32'h0000_0000, 32'd100, 1'b0, STATUS_OK, 8'd0);
    add_known(32'hffff_ffff, 32'd100, 1'b1, STATUS_OK, 8'd0);
    // sectored build: sector counter wraps at the count
    add_reg(REG_FORMAT, {10'd0, FMT_SECTOR});
    add_reg(REG_SECTORS, 12'd2);
    add_reg(REG_TRACK, 12'd1);
    add_reg(REG_LENGTH, 12'd2);
    add_known(32'h1111_1111, 32'h0000_0100, 1'b0, STATUS_OK, 8'd0);
    add_known(32'h2222_2222, 32'h0000_0100, 1'b1, STATUS_OK, 8'd0);
    add_known(32'h3333_3333, 32'h0000_0101, 1'b0, STATUS_OK, 8'd1);
    add_known(32'h4444_4444, 32'h0000_0101, 1'b1, STATUS_OK, 8'd1);
    add_known(32'h5555_5555, 32'h0000_0100, 1'b0, STATUS_OK, 8'd0);
    add_word(32'h6666_6666);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) cfg_write(plan[i].idx, plan[i].val);
      else send_word(plan[i].word, plan[i].known, plan[i].want);
    end

    while (items_sent < RANDOM_ITEMS) begin
      for (int r = REG_FORMAT; r <= REG_SECTORS; r++) begin
        if ($urandom_range(1) == 0) continue;
        val = 12'($urandom);
        case (r)
          REG_LENGTH: begin
            k = $urandom_range(99);
            if (k < 70) val = 12'($urandom_range(2, 12));
            else if (k < 80) val = 12'($urandom_range(0, 1));
            else val = 12'($urandom_range(13, 80));
          end
          REG_SECTORS: begin
            k = $urandom_range(99);
            if (k < 80) val[7:0] = 8'($urandom_range(1, 16));
            else if (k < 90) val[7:0] = 8'd0;
          end
          default: ;
        endcase
        cfg_write(CFG_ADDR_W'(r), val);
      end
      if ($urandom_range(7) == 0)
        cfg_write(CFG_ADDR_W'($urandom_range(REG_SPARE, REG_SECTORS + 1)), 12'($urandom));

      // longest length, then cut short while a block is open
      if ($urandom_range(14) == 0) begin
        cfg_write(REG_LENGTH, 12'hfff);
        repeat ($urandom_range(1, 20)) send_word($urandom, 1'b0, '0);
        cfg_write(REG_LENGTH, 12'($urandom_range(2, 6)));
      end

      // finish any open block with noise
      while (blk_pos != 0) send_word($urandom, 1'b0, '0);

      repeat ($urandom_range(1, 6)) begin
        n = eff_length();
        if (cur_build) begin
          repeat (n) send_word($urandom, 1'b0, '0);
        end else begin
          // well-formed block with the odd flipped bit
          prev = CHAIN_START;
          run_sum = '0;
          bad_pos = ($urandom_range(99) < 20) ? $urandom_range(n - 1) : -1;
          for (int i = 0; i < n; i++) begin
            if (i == 0) begin
              if (cur_format == FMT_SECTOR)
                p = {16'($urandom), cur_track,
                     8'((cur_sectors == 0) ? 0 : $urandom_range(cur_sectors - 1))};
              else
                p = {24'd0, 1'b0, cur_track[7:1]};
            end else if (i == n - 1) begin
              p = run_sum;
            end else begin
              p = $urandom;
            end
            if (i != n - 1) run_sum = run_sum + p;
            w = (i != 0 && cur_format == FMT_CHAIN) ? (p ^ prev) : p;
            if (i != 0) prev = p;
            if (i == bad_pos) w = w ^ (32'd1 << $urandom_range(31));
            send_word(w, 1'b0, '0);
          end
        end
      end

      // sometimes leave a block open across the next register writes
      if ($urandom_range(3) == 0)
        repeat ($urandom_range(1, 3)) send_word($urandom, 1'b0, '0);
    end

    word_ch.valid <= 1'b0;
    cfg_ch.valid  <= 1'b0;
    settle();
    if (fail_count == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule
